// ----- rtl/core/certificate_entry_list_deframer_core_assert.svh -----
// assertion macros for the certificate entry list deframer
`ifndef CERTIFICATE_ENTRY_LIST_DEFRAMER_CORE_ASSERT_SVH
`define CERTIFICATE_ENTRY_LIST_DEFRAMER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// property must hold at every rising clock edge out of reset
`define CELD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be seen at a rising clock edge out of reset
`define CELD_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define CELD_ASSERT(label, clk, rst_n, prop, msg)
`define CELD_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

// ----- rtl/core/celd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package celd_pkg;

    localparam int MAX_ENTRIES    = 8;
    localparam int MAX_CERT_BYTES = 16384;

    // parse phases
    localparam logic [2:0] PH_LEN0 = 3'd0;
    localparam logic [2:0] PH_LEN1 = 3'd1;
    localparam logic [2:0] PH_LEN2 = 3'd2;
    localparam logic [2:0] PH_BODY = 3'd3;
    localparam logic [2:0] PH_EXT0 = 3'd4;
    localparam logic [2:0] PH_EXT1 = 3'd5;

    // alert codes
    localparam logic [1:0] ALERT_NONE      = 2'd0;
    localparam logic [1:0] ALERT_BAD_CERT  = 2'd1;
    localparam logic [1:0] ALERT_UNSUP_EXT = 2'd2;

    // result kinds
    localparam logic KIND_ENTRY   = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = FIFO_AW + 1;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  entry_index;
        logic [23:0] cert_offset;
        logic [23:0] cert_length;
        logic        status;
        logic [1:0]  alert_code;
        logic [7:0]  entry_count;
        logic        last_result;
    } result_t;

    // zero, one or two results produced by one accepted request
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

`default_nettype wire

// ----- rtl/core/celd_channels.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface celd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_list;

    modport source (output valid, data_byte, byte_present, end_of_list, input ready);
    modport sink (input valid, data_byte, byte_present, end_of_list, output ready);
endinterface

interface celd_result_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [7:0]  entry_index;
    logic [23:0] cert_offset;
    logic [23:0] cert_length;
    logic        status;
    logic [1:0]  alert_code;
    logic [7:0]  entry_count;
    logic        last_result;

    modport source (output valid, result_kind, entry_index, cert_offset, cert_length,
                    status, alert_code, entry_count, last_result, input ready);
    modport sink (input valid, result_kind, entry_index, cert_offset, cert_length,
                  status, alert_code, entry_count, last_result, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/celd_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none

module celd_parser (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           accept,
    input  wire logic [7:0]     data_byte,
    input  wire logic           byte_present,
    input  wire logic           end_of_list,
    output celd_pkg::push_t     push
);

    logic [2:0]  phase_reg,      phase_next;
    logic [23:0] len_acc_reg,    len_acc_next;
    logic [23:0] body_rem_reg,   body_rem_next;
    logic [7:0]  ext_hi_reg,     ext_hi_next;
    logic [7:0]  entries_reg,    entries_next;
    logic [23:0] pos_reg,        pos_next;
    logic [23:0] body_start_reg, body_start_next;
    logic [1:0]  alert_reg,      alert_next;

    logic [23:0]         acc_shift;
    logic                entry_done;
    logic [1:0]          verdict_alert;
    logic [7:0]          verdict_count;
    celd_pkg::result_t   entry_res;
    celd_pkg::result_t   verdict_res;

    assign acc_shift = {len_acc_reg[15:0], data_byte};

    always_comb
    begin
        phase_next      = phase_reg;
        len_acc_next    = len_acc_reg;
        body_rem_next   = body_rem_reg;
        ext_hi_next     = ext_hi_reg;
        entries_next    = entries_reg;
        pos_next        = pos_reg;
        body_start_next = body_start_reg;
        alert_next      = alert_reg;
        entry_done      = 1'b0;
        verdict_alert   = celd_pkg::ALERT_NONE;
        verdict_count   = 8'd0;

        if (accept && byte_present)
        begin
            pos_next = pos_reg + 24'd1;
            if (alert_reg == celd_pkg::ALERT_NONE)
            begin
                unique case (phase_reg)
                    celd_pkg::PH_LEN0:
                    begin
                        if (entries_reg >= 8'(celd_pkg::MAX_ENTRIES))
                            alert_next = celd_pkg::ALERT_BAD_CERT;
                        else
                        begin
                            len_acc_next = {16'd0, data_byte};
                            phase_next   = celd_pkg::PH_LEN1;
                        end
                    end
                    celd_pkg::PH_LEN1:
                    begin
                        len_acc_next = acc_shift;
                        phase_next   = celd_pkg::PH_LEN2;
                    end
                    celd_pkg::PH_LEN2:
                    begin
                        len_acc_next = acc_shift;
                        if (acc_shift == 24'd0 || acc_shift > 24'(celd_pkg::MAX_CERT_BYTES))
                            alert_next = celd_pkg::ALERT_BAD_CERT;
                        else
                        begin
                            body_rem_next   = acc_shift;
                            body_start_next = pos_next;
                            phase_next      = celd_pkg::PH_BODY;
                        end
                    end
                    celd_pkg::PH_BODY:
                    begin
                        body_rem_next = body_rem_reg - 24'd1;
                        if (body_rem_reg == 24'd1)
                            phase_next = celd_pkg::PH_EXT0;
                    end
                    celd_pkg::PH_EXT0:
                    begin
                        ext_hi_next = data_byte;
                        phase_next  = celd_pkg::PH_EXT1;
                    end
                    celd_pkg::PH_EXT1:
                    begin
                        if (ext_hi_reg != 8'd0 || data_byte != 8'd0)
                            alert_next = celd_pkg::ALERT_UNSUP_EXT;
                        else
                        begin
                            entry_done   = 1'b1;
                            entries_next = entries_reg + 8'd1;
                            phase_next   = celd_pkg::PH_LEN0;
                        end
                    end
                    default:
                        phase_next = celd_pkg::PH_LEN0;
                endcase
            end
        end

        if (accept && end_of_list)
        begin
            // truncated entry or empty list
            verdict_alert = alert_next;
            if (alert_next == celd_pkg::ALERT_NONE &&
                (phase_next != celd_pkg::PH_LEN0 || entries_next == 8'd0))
                verdict_alert = celd_pkg::ALERT_BAD_CERT;
            verdict_count = entries_next;
            // back to reset for the next list
            phase_next      = celd_pkg::PH_LEN0;
            len_acc_next    = 24'd0;
            body_rem_next   = 24'd0;
            ext_hi_next     = 8'd0;
            entries_next    = 8'd0;
            pos_next        = 24'd0;
            body_start_next = 24'd0;
            alert_next      = celd_pkg::ALERT_NONE;
        end
    end

    always_comb
    begin
        entry_res             = '0;
        entry_res.result_kind = celd_pkg::KIND_ENTRY;
        entry_res.entry_index = entries_reg;
        entry_res.cert_offset = body_start_reg;
        entry_res.cert_length = len_acc_reg;
        entry_res.last_result = !end_of_list;

        verdict_res             = '0;
        verdict_res.result_kind = celd_pkg::KIND_VERDICT;
        verdict_res.status      = (verdict_alert != celd_pkg::ALERT_NONE);
        verdict_res.alert_code  = verdict_alert;
        verdict_res.entry_count = verdict_count;
        verdict_res.last_result = 1'b1;

        push.first  = entry_done ? entry_res : verdict_res;
        push.second = verdict_res;
        push.count  = 2'(entry_done) + 2'(accept && end_of_list);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= celd_pkg::PH_LEN0;
            len_acc_reg    <= 24'd0;
            body_rem_reg   <= 24'd0;
            ext_hi_reg     <= 8'd0;
            entries_reg    <= 8'd0;
            pos_reg        <= 24'd0;
            body_start_reg <= 24'd0;
            alert_reg      <= celd_pkg::ALERT_NONE;
        end
        else
        begin
            phase_reg      <= phase_next;
            len_acc_reg    <= len_acc_next;
            body_rem_reg   <= body_rem_next;
            ext_hi_reg     <= ext_hi_next;
            entries_reg    <= entries_next;
            pos_reg        <= pos_next;
            body_start_reg <= body_start_next;
            alert_reg      <= alert_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/celd_result_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "certificate_entry_list_deframer_core_assert.svh"

module celd_result_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire celd_pkg::push_t   push,
    input  wire logic              pop,
    output celd_pkg::result_t      head,
    output logic                   not_empty,
    output logic                   room
);

    localparam int AW = celd_pkg::FIFO_AW;
    localparam int CW = celd_pkg::FIFO_CW;

    localparam logic [CW-1:0] DEPTH_CNT = CW'(celd_pkg::FIFO_DEPTH);

    celd_pkg::result_t mem [celd_pkg::FIFO_DEPTH];

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg,  count_next;

    // assertion helpers
    logic          pushing;
    logic          one_pop;
    logic [CW-1:0] count_dec;

    assign head      = mem[rd_ptr_reg];
    assign not_empty = (count_reg != CW'(0));
    // room for the worst case of two results from one request
    assign room      = (count_reg <= CW'(celd_pkg::FIFO_DEPTH - 2));

    assign pushing   = (push.count != 2'd0);
    assign one_pop   = pop && !pushing;
    assign count_dec = count_reg - CW'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + AW'(push.count);
        rd_ptr_next = rd_ptr_reg + AW'(pop);
        count_next  = count_reg + CW'(push.count) - CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            mem[wr_ptr_reg + AW'(1)] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `CELD_ASSERT(a_push_has_room, clk, rst_n, pushing |-> room, "results pushed without room")
    `CELD_ASSERT_NEVER(a_count_bound, clk, rst_n, count_reg > DEPTH_CNT, "result queue overflow")
    `CELD_ASSERT(a_pop_drain, clk, rst_n, one_pop |=> (count_reg == $past(count_dec)), "pop lost")

endmodule

`default_nettype wire

// ----- rtl/core/certificate_entry_list_deframer_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// certificate entry list deframer
// stream: one request per list byte (data_byte with byte_present), or a bare
//   end_of_list request; end_of_list marks the final request of a list and
//   any byte on it is taken before the verdict
// result: an entry result when an entry's extensions length completes at zero,
//   and a verdict result on end_of_list; last_result marks the final result
//   of a request, which can cause up to two
// one request is accepted per cycle while the result queue has room; each is
//   resolved in the cycle it is accepted by the phase logic, and its results
//   are written into a four-deep result queue
// stream.ready drops only when the result queue lacks room for two results,
//   which happens only when the receiver holds result.ready low
// a stalled receiver simply backs up into the queue; nothing is dropped
// reset clears the parse state and empties the queue; after every verdict the
//   parse state returns to its reset value for the next list
module certificate_entry_list_deframer_core (
    input wire logic       clk,
    input wire logic       rst_n,
    celd_byte_if.sink      stream,
    celd_result_if.source  result
);

    logic              accept;
    logic              pop;
    logic              room;
    logic              not_empty;
    celd_pkg::push_t   push;
    celd_pkg::result_t head;

    // request handshake
    assign stream.ready = room;
    assign accept       = stream.valid && stream.ready;

    // phase tracking, length capture and verdict
    celd_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .data_byte    (stream.data_byte),
        .byte_present (stream.byte_present),
        .end_of_list  (stream.end_of_list),
        .push         (push)
    );

    // result queue decouples the receiver from the byte stream
    celd_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .room      (room)
    );

    assign result.valid       = not_empty;
    assign pop                = result.valid && result.ready;
    assign result.result_kind = head.result_kind;
    assign result.entry_index = head.entry_index;
    assign result.cert_offset = head.cert_offset;
    assign result.cert_length = head.cert_length;
    assign result.status      = head.status;
    assign result.alert_code  = head.alert_code;
    assign result.entry_count = head.entry_count;
    assign result.last_result = head.last_result;

endmodule

`default_nettype wire

// ----- verif/tb_certificate_entry_list_deframer_core.sv -----
`timescale 1ns / 1ps

module tb_certificate_entry_list_deframer_core;

    // run bounds: a request budget, then limits in clock cycles
    localparam int RANDOM_REQUESTS = 600;
    localparam int CYCLE_LIMIT     = 1_500_000;
    localparam int DRAIN_LIMIT     = 20_000;
    localparam int SETTLE_CYCLES   = 16;

    logic clk = 1'b0;
    logic rst_n;

    celd_byte_if   stream_ch ();
    celd_result_if result_ch ();

    certificate_entry_list_deframer_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_ch),
        .result (result_ch)
    );

    // 2 ns period
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // shadow of the deframer's parse state, advanced once per accepted
    // request; the results it produces are queued in arrival order
    // ------------------------------------------------------------------
    logic [2:0]  parse_phase;
    logic [23:0] length_so_far;
    logic [23:0] body_left;
    logic [7:0]  ext_high;
    logic [7:0]  entries_framed;
    logic [23:0] list_pos;
    logic [23:0] body_origin;
    logic [1:0]  list_alert;

    celd_pkg::result_t due_results[$];

    // bytes of the list being sent next
    logic [7:0]  list_bytes[$];

    int          mismatch_count = 0;
    int          requests_sent  = 0;
    int          cycle_count    = 0;

    // idling controls, flipped by the tests
    bit          tx_idle_en  = 1'b0;
    bit          rx_stall_en = 1'b0;
    bit          noise_en    = 1'b0;

    function automatic void clear_list_state();
        parse_phase    = celd_pkg::PH_LEN0;
        length_so_far  = '0;
        body_left      = '0;
        ext_high       = '0;
        entries_framed = '0;
        list_pos       = '0;
        body_origin    = '0;
        list_alert     = celd_pkg::ALERT_NONE;
    endfunction

    // work out what one accepted request produces: an entry result when the
    // extensions length closes an entry at zero, then a verdict on end_of_list
    function automatic void frame_request(input logic [7:0] b, input logic present,
                                          input logic eol);
        celd_pkg::result_t entry_r;
        celd_pkg::result_t verdict_r;
        bit                have_entry;
        have_entry = 1'b0;
        entry_r    = '0;
        verdict_r  = '0;

        if (present)
        begin
            // the position counts every byte, even those ignored after an error
            list_pos = list_pos + 24'd1;
            if (list_alert == celd_pkg::ALERT_NONE)
            begin
                case (parse_phase)
                    celd_pkg::PH_LEN0:
                    begin
                        // a ninth entry starting is a bad certificate
                        if (entries_framed >= celd_pkg::MAX_ENTRIES)
                            list_alert = celd_pkg::ALERT_BAD_CERT;
                        else
                        begin
                            length_so_far = {16'h0000, b};
                            parse_phase   = celd_pkg::PH_LEN1;
                        end
                    end
                    celd_pkg::PH_LEN1:
                    begin
                        length_so_far = {length_so_far[15:0], b};
                        parse_phase   = celd_pkg::PH_LEN2;
                    end
                    celd_pkg::PH_LEN2:
                    begin
                        length_so_far = {length_so_far[15:0], b};
                        // zero or oversize body length
                        if (length_so_far == 24'd0 ||
                            length_so_far > celd_pkg::MAX_CERT_BYTES)
                            list_alert = celd_pkg::ALERT_BAD_CERT;
                        else
                        begin
                            body_left   = length_so_far;
                            body_origin = list_pos;
                            parse_phase = celd_pkg::PH_BODY;
                        end
                    end
                    celd_pkg::PH_BODY:
                    begin
                        body_left = body_left - 24'd1;
                        if (body_left == 24'd0)
                            parse_phase = celd_pkg::PH_EXT0;
                    end
                    celd_pkg::PH_EXT0:
                    begin
                        ext_high    = b;
                        parse_phase = celd_pkg::PH_EXT1;
                    end
                    celd_pkg::PH_EXT1:
                    begin
                        // any extension at all is refused, and the entry is dropped
                        if (ext_high != 8'h00 || b != 8'h00)
                            list_alert = celd_pkg::ALERT_UNSUP_EXT;
                        else
                        begin
                            entry_r.result_kind = celd_pkg::KIND_ENTRY;
                            entry_r.entry_index = entries_framed;
                            entry_r.cert_offset = body_origin;
                            entry_r.cert_length = length_so_far;
                            have_entry          = 1'b1;
                            entries_framed      = entries_framed + 8'd1;
                            parse_phase         = celd_pkg::PH_LEN0;
                        end
                    end
                    default:
                        parse_phase = celd_pkg::PH_LEN0;
                endcase
            end
        end

        if (eol)
        begin
            // truncated entry, or a list with nothing framed
            if (list_alert == celd_pkg::ALERT_NONE &&
                (parse_phase != celd_pkg::PH_LEN0 || entries_framed == 8'd0))
                list_alert = celd_pkg::ALERT_BAD_CERT;
            verdict_r.result_kind = celd_pkg::KIND_VERDICT;
            verdict_r.status      = (list_alert != celd_pkg::ALERT_NONE);
            verdict_r.alert_code  = list_alert;
            verdict_r.entry_count = entries_framed;
            verdict_r.last_result = 1'b1;
            clear_list_state();
        end
        else
            entry_r.last_result = 1'b1;

        if (have_entry)
            due_results.push_back(entry_r);
        if (eol)
            due_results.push_back(verdict_r);
    endfunction

    // mostly short, now and then long
    function automatic int pick_idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [23:0] pick_cert_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return 24'($urandom_range(1, 8));
        else if (r < 97)
            return 24'($urandom_range(9, 200));
        return 24'($urandom_range(201, 600));
    endfunction

    function automatic void append_length(input logic [23:0] len);
        list_bytes.push_back(len[23:16]);
        list_bytes.push_back(len[15:8]);
        list_bytes.push_back(len[7:0]);
    endfunction

    function automatic void append_entry(input logic [23:0] len, input logic [15:0] ext);
        append_length(len);
        repeat (len)
            list_bytes.push_back(8'($urandom_range(0, 255)));
        list_bytes.push_back(ext[15:8]);
        list_bytes.push_back(ext[7:0]);
    endfunction

    // ------------------------------------------------------------------
    // stream side: one request per call, driven at the falling edge and
    // taken as accepted at the first rising edge that sees ready high
    // ------------------------------------------------------------------
    task automatic send_request(input logic [7:0] b, input logic present, input logic eol);
        int gap;
        gap = (tx_idle_en && $urandom_range(0, 3) == 0) ? pick_idle_len() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            stream_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        stream_ch.valid        <= 1'b1;
        stream_ch.data_byte    <= b;
        stream_ch.byte_present <= present;
        stream_ch.end_of_list  <= eol;
        do
            @(posedge clk);
        while (!stream_ch.ready);
        frame_request(b, present, eol);
        // bare filler requests do not count toward the random budget
        if (present || eol)
            requests_sent++;
    endtask

    // send the collected list, closing it either on its last byte or with
    // a bare end_of_list request; an empty list is just the bare request
    task automatic send_list(input bit eol_on_byte);
        int n;
        n = list_bytes.size();
        for (int i = 0; i < n; i++)
        begin
            if (noise_en && $urandom_range(0, 19) == 0)
                send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_request(list_bytes[i], 1'b1, eol_on_byte && i == n - 1);
        end
        if (!eol_on_byte || n == 0)
            send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        list_bytes.delete();
    endtask

    // ------------------------------------------------------------------
    // result side: ready with random stalls, checked at the rising edge
    // ------------------------------------------------------------------
    initial
    begin : result_ready_driver
        int hold;
        hold = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
                hold--;
            else if (rx_stall_en && $urandom_range(0, 3) == 0)
            begin
                result_ch.ready <= 1'b0;
                hold = pick_idle_len();
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [23:0] want,
                               input logic [23:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_checker
        celd_pkg::result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (due_results.size() == 0)
            begin
                $error("result with nothing pending: kind %0d index %0d",
                       result_ch.result_kind, result_ch.entry_index);
                mismatch_count++;
            end
            else
            begin
                want = due_results.pop_front();
                check_field("result_kind", 24'(want.result_kind),
                            24'(result_ch.result_kind));
                check_field("entry_index", 24'(want.entry_index),
                            24'(result_ch.entry_index));
                check_field("cert_offset", want.cert_offset, result_ch.cert_offset);
                check_field("cert_length", want.cert_length, result_ch.cert_length);
                check_field("status", 24'(want.status), 24'(result_ch.status));
                check_field("alert_code", 24'(want.alert_code),
                            24'(result_ch.alert_code));
                check_field("entry_count", 24'(want.entry_count),
                            24'(result_ch.entry_count));
                check_field("last_result", 24'(want.last_result),
                            24'(result_ch.last_result));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // framing edges and each error path, one short list per case
    task automatic test_directed_framing();
        tx_idle_en  = 1'b1;
        rx_stall_en = 1'b1;
        noise_en    = 1'b0;

        // filler request with nothing in it, then an empty list
        send_request(8'hA5, 1'b0, 1'b0);
        send_list(1'b0);

        // smallest entry, closed by a bare end
        append_entry(24'd1, 16'h0000);
        send_list(1'b0);

        // end_of_list on the closing extensions byte: entry and verdict together
        append_entry(24'd2, 16'h0000);
        append_entry(24'd1, 16'h0000);
        send_list(1'b1);

        // zero length, then a byte that is ignored and carries the end
        append_length(24'd0);
        list_bytes.push_back(8'hFF);
        send_list(1'b1);

        // one past the largest body, and an all-ones length
        append_length(24'(celd_pkg::MAX_CERT_BYTES + 1));
        send_list(1'b0);
        append_length(24'hFFFFFF);
        send_list(1'b0);

        // nonzero extensions length, high byte then low byte; the entry after
        // the error is ignored
        append_entry(24'd1, 16'h8000);
        send_list(1'b0);
        append_entry(24'd1, 16'h0001);
        append_entry(24'd1, 16'h0000);
        send_list(1'b0);
        append_entry(24'd3, 16'hFFFF);
        send_list(1'b1);

        // truncation inside the length, inside the body and inside the extensions
        list_bytes.push_back(8'h00);
        send_list(1'b0);
        append_length(24'd4);
        list_bytes.push_back(8'h00);
        list_bytes.push_back(8'hFF);
        send_list(1'b1);
        append_length(24'd1);
        list_bytes.push_back(8'h5A);
        list_bytes.push_back(8'h00);
        send_list(1'b0);

        // exactly the entry limit, then one byte too many
        repeat (celd_pkg::MAX_ENTRIES) append_entry(24'd1, 16'h0000);
        send_list(1'b1);
        repeat (celd_pkg::MAX_ENTRIES) append_entry(24'd1, 16'h0000);
        list_bytes.push_back(8'h00);
        send_list(1'b0);
    endtask

    // mostly well-formed lists with random sizes and content, plus broken,
    // truncated and garbage lists, with filler requests mixed in
    task automatic test_random_lists();
        int          start_count;
        int          shape;
        int          n_entries;
        int          pick;
        int          cut;
        bit          broken;
        logic [23:0] len;

        noise_en    = 1'b1;
        start_count = requests_sent;
        while (requests_sent - start_count < RANDOM_REQUESTS)
        begin
            // some lists run with no idling on either side
            tx_idle_en  = ($urandom_range(0, 4) != 0);
            rx_stall_en = ($urandom_range(0, 4) != 0);

            shape = $urandom_range(0, 99);
            if (shape < 5)
            begin
                repeat ($urandom_range(1, 20))
                    list_bytes.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                if (shape < 10)
                    n_entries = 0;
                else if (shape < 20)
                    n_entries = celd_pkg::MAX_ENTRIES + 1;
                else
                    n_entries = $urandom_range(1, celd_pkg::MAX_ENTRIES);
                broken = 1'b0;
                for (int i = 0; i < n_entries && !broken; i++)
                begin
                    pick = $urandom_range(0, 99);
                    len  = pick_cert_len();
                    if (pick < 3)
                    begin
                        append_length(24'd0);
                        broken = 1'b1;
                    end
                    else if (pick < 6)
                    begin
                        append_length(24'($urandom_range(celd_pkg::MAX_CERT_BYTES + 1,
                                                         24'hFFFFFF)));
                        broken = 1'b1;
                    end
                    else if (pick < 10)
                    begin
                        append_entry(len, 16'($urandom_range(1, 16'hFFFF)));
                        broken = 1'b1;
                    end
                    else
                        append_entry(len, 16'h0000);
                end
                // bytes after an error are ignored by the block
                if (broken)
                    repeat ($urandom_range(0, 6))
                        list_bytes.push_back(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 99) < 8 && list_bytes.size() > 1)
                begin
                    cut = $urandom_range(1, list_bytes.size() - 1);
                    while (list_bytes.size() > cut)
                        void'(list_bytes.pop_back());
                end
            end
            send_list(1'($urandom_range(0, 1)));
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin : main_sequence
        int waited;
        rst_n                  = 1'b0;
        stream_ch.valid        = 1'b0;
        stream_ch.data_byte    = 8'h00;
        stream_ch.byte_present = 1'b0;
        stream_ch.end_of_list  = 1'b0;
        clear_list_state();

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_framing();
        test_random_lists();

        @(negedge clk);
        stream_ch.valid <= 1'b0;

        // let every pending result come out, then a few idle cycles for strays
        for (waited = 0; waited < DRAIN_LIMIT && due_results.size() != 0; waited++)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (due_results.size() != 0)
        begin
            $error("%0d expected results never arrived", due_results.size());
            mismatch_count++;
        end

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/celd_pkg.sv
rtl/core/celd_channels.sv
rtl/core/celd_parser.sv
rtl/core/celd_result_fifo.sv
rtl/core/certificate_entry_list_deframer_core.sv
verif/tb_certificate_entry_list_deframer_core.sv
